### design/p3g_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3g_pkg
// Shared types and constants for the pseudo-3D ground scroll / palette block.
// ----------------------------------------------------------------------------
package p3g_pkg;

    // Geometry defaults
    localparam int HORIZON_ROW_DEF = 96;
    localparam int LINE_LIMIT_DEF  = 240;

    // Frame and ramp constants
    localparam int PAD_TOP       = 64;
    localparam int START_PAD     = 2;
    localparam int CENTER_SCROLL = -32;
    localparam int SCROLL_MIN    = -64;
    localparam int SWAY_ROUND    = 512;
    localparam int SWAY_SHIFT    = 10;
    localparam int VANISH_SHR    = 3;
    localparam int ANIM_MUL      = 21;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int LINE_W    = 8;
    localparam int HEIGHT_W  = 8;
    localparam int COLOR_W   = 12;
    localparam int INDEX_W   = 3;
    localparam int SCROLL_W  = 7;
    localparam int VANISH_W  = COORD_W - VANISH_SHR;
    localparam int DIFF_W    = 18;
    localparam int PROD_W    = COORD_W + DIFF_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 12;

    localparam int S_TDATA_W = 4 * COORD_W + LINE_W;
    localparam int M_TDATA_W = 56;

    // Register reset values
    localparam logic [HEIGHT_W-1:0] SCREEN_HEIGHT_RST = 8'd224;
    localparam logic [COLOR_W-1:0]  LIGHT_COLOR_RST   = 12'd3206;
    localparam logic [COLOR_W-1:0]  DARK_COLOR_RST    = 12'd2114;

    typedef enum logic {
        CMD_FRAME = 1'b0,
        CMD_LINE  = 1'b1
    } t_cmd;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SCREEN_HEIGHT = 2'd0,
        REG_LIGHT_COLOR   = 2'd1,
        REG_DARK_COLOR    = 2'd2
    } t_cfg_reg;

    // Line classification captured when a query is accepted
    typedef struct packed {
        logic beyond;   // line at or below effective height
        logic above;    // line above the checker start row
    } t_line_flags;

endpackage

### design/p3g_frame.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3g_frame
// Next-frame state: vertical scroll, horizon, start row, vanish offset and
// forward accumulator.
// ----------------------------------------------------------------------------
module p3g_frame #(
    parameter int HORIZON_ROW = p3g_pkg::HORIZON_ROW_DEF
) (
    input  logic signed [p3g_pkg::COORD_W-1:0]  i_pitch,
    input  logic signed [p3g_pkg::COORD_W-1:0]  i_vanish,
    input  logic        [p3g_pkg::COORD_W-1:0]  i_speed,
    input  logic        [p3g_pkg::COORD_W-1:0]  i_fwd,
    input  logic        [p3g_pkg::HEIGHT_W-1:0] i_height,
    output logic signed [p3g_pkg::COORD_W-1:0]  o_vscroll,
    output logic signed [p3g_pkg::COORD_W-1:0]  o_horizon,
    output logic        [p3g_pkg::HEIGHT_W-1:0] o_start_row,
    output logic signed [p3g_pkg::VANISH_W-1:0] o_vanish,
    output logic        [p3g_pkg::COORD_W-1:0]  o_fwd
);

    localparam int CW = p3g_pkg::COORD_W;

    logic signed [CW-1:0] half_pitch;
    logic signed [CW:0]   start_full;

    always_comb begin
        half_pitch = i_pitch >>> 1;
        o_vscroll  = signed'(CW'(p3g_pkg::PAD_TOP)) + half_pitch;
        // horizon = HORIZON_ROW + PAD_TOP - vscroll
        o_horizon  = signed'(CW'(HORIZON_ROW)) - half_pitch;
        start_full = (CW+1)'(o_horizon) + signed'((CW+1)'(p3g_pkg::START_PAD));
        if (start_full < 0) begin
            o_start_row = '0;
        end else if (start_full > signed'({{(CW+1-p3g_pkg::HEIGHT_W){1'b0}}, i_height})) begin
            o_start_row = i_height;
        end else begin
            o_start_row = start_full[p3g_pkg::HEIGHT_W-1:0];
        end
        o_vanish = i_vanish[CW-1:p3g_pkg::VANISH_SHR];
        o_fwd    = i_fwd + CW'(i_speed * CW'(p3g_pkg::ANIM_MUL));
    end

endmodule

### design/p3g_palette.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3g_palette
// Checker palette entry: light, dark or quarter-step blend, rotated by band.
// ----------------------------------------------------------------------------
module p3g_palette (
    input  logic [p3g_pkg::COLOR_W-1:0] i_light,
    input  logic [p3g_pkg::COLOR_W-1:0] i_dark,
    input  logic [2:0]                  i_band,
    input  logic [1:0]                  i_sub,
    input  logic [p3g_pkg::INDEX_W-1:0] i_index,
    output logic [p3g_pkg::COLOR_W-1:0] o_color
);

    // Per channel a + floor((b - a) * num / 4); channels at bits 1, 5 and 9
    function automatic logic [p3g_pkg::COLOR_W-1:0] blend(
        input logic [p3g_pkg::COLOR_W-1:0] a,
        input logic [p3g_pkg::COLOR_W-1:0] b,
        input logic [1:0]                  num
    );
        logic [p3g_pkg::COLOR_W-1:0] res;
        logic signed [4:0] av;
        logic signed [4:0] bv;
        logic signed [4:0] d;
        logic signed [6:0] p;
        logic signed [6:0] c;
        res = '0;
        for (int ch = 0; ch < 3; ch++) begin
            av = signed'({2'b00, a[ch*4+1 +: 3]});
            bv = signed'({2'b00, b[ch*4+1 +: 3]});
            d  = bv - av;
            p  = 7'(d) * signed'({5'b00000, num});
            c  = 7'(av) + (p >>> 2);
            res[ch*4+1 +: 3] = c[2:0];
        end
        return res;
    endfunction

    logic [p3g_pkg::INDEX_W-1:0] q;

    always_comb begin
        q = i_index + i_band;
        unique case (q)
            3'd0, 3'd1, 3'd2: o_color = i_light;
            3'd3:             o_color = blend(i_light, i_dark, i_sub);
            3'd4, 3'd5, 3'd6: o_color = i_dark;
            3'd7:             o_color = blend(i_dark, i_light, i_sub);
            default:          o_color = i_light;
        endcase
    end

endmodule

### design/p3g_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// p3g_ramp
// Scanline horizontal scroll from the registered sway product.
// ----------------------------------------------------------------------------
module p3g_ramp (
    input  logic signed [p3g_pkg::PROD_W-1:0]   i_product,
    input  logic signed [p3g_pkg::VANISH_W-1:0] i_vanish,
    input  p3g_pkg::t_line_flags                i_flags,
    output logic signed [p3g_pkg::SCROLL_W-1:0] o_line_scroll
);

    localparam int PW = p3g_pkg::PROD_W;
    localparam int SW = PW - p3g_pkg::SWAY_SHIFT;
    localparam int FW = SW + 3;

    logic signed [PW-1:0] acc;
    logic signed [SW-1:0] shifted;
    logic signed [FW-1:0] full;

    always_comb begin
        acc     = i_product + signed'(PW'(p3g_pkg::SWAY_ROUND));
        shifted = acc[PW-1:p3g_pkg::SWAY_SHIFT];
        full    = signed'(FW'(p3g_pkg::CENTER_SCROLL)) - FW'(shifted) - FW'(i_vanish);
        if (i_flags.beyond) begin
            o_line_scroll = '0;
        end else if (i_flags.above) begin
            o_line_scroll = p3g_pkg::SCROLL_W'(p3g_pkg::CENTER_SCROLL);
        end else if (full < signed'(FW'(p3g_pkg::SCROLL_MIN))) begin
            o_line_scroll = p3g_pkg::SCROLL_W'(p3g_pkg::SCROLL_MIN);
        end else if (full > 0) begin
            o_line_scroll = '0;
        end else begin
            o_line_scroll = full[p3g_pkg::SCROLL_W-1:0];
        end
    end

endmodule

### design/pseudo3d_ground_scroll_palette_gen.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pseudo3d_ground_scroll_palette_gen
// Pseudo-3D ground: per-frame horizon / checker palette, per-line scroll.
// ----------------------------------------------------------------------------
// A frame update (tuser = 0) is absorbed into the frame state at the edge it
// is accepted and then yields 8 palette results, one per cycle while the
// output is not stalled, from a 3-bit entry counter in the issue stage; the
// input is held off while the first seven entries issue and a new item can
// be taken with the eighth. A line query (tuser = 1) is accepted every cycle
// while the output is not stalled and yields one result. The sway multiply
// is done at acceptance into the issue register, the rounding and clamp into
// the output register; a new item can enter an empty issue register while a
// result waits. Configuration is written through the cfg channel; the user
// must write it only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module pseudo3d_ground_scroll_palette_gen #(
    parameter int HORIZON_ROW = p3g_pkg::HORIZON_ROW_DEF,
    parameter int LINE_LIMIT  = p3g_pkg::LINE_LIMIT_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // stream in
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // sway_x[15:0], pitch_y[31:16], vanish_x[47:32], speed[63:48], line[71:64]
    input  logic [p3g_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // cmd[0]
    input  logic                              i_s_tuser,
    // stream out
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // vertical_scroll[15:0], horizon_row[31:16], pal_index[34:32],
    // pal_color[46:35], line_scroll[53:47], zero[55:54]
    output logic [p3g_pkg::M_TDATA_W-1:0]     o_m_tdata,
    // beyond_screen[0]
    output logic                              o_m_tuser,
    output logic                              o_m_tlast,
    // configuration write
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [p3g_pkg::CFG_ADDR_W-1:0]    i_cfg_addr,
    input  logic [p3g_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int CW = p3g_pkg::COORD_W;
    localparam int HW = p3g_pkg::HEIGHT_W;
    localparam int LW = p3g_pkg::LINE_W;
    localparam int KW = p3g_pkg::INDEX_W;
    localparam int DW = p3g_pkg::DIFF_W;
    localparam int PW = p3g_pkg::PROD_W;
    localparam int VW = p3g_pkg::VANISH_W;

    // configuration
    logic [HW-1:0]               r_screen_height;
    logic [p3g_pkg::COLOR_W-1:0] r_light;
    logic [p3g_pkg::COLOR_W-1:0] r_dark;

    // frame state
    logic [CW-1:0]        r_fwd;
    logic signed [CW-1:0] r_horizon;
    logic signed [CW-1:0] r_vscroll;
    logic [HW-1:0]        r_start_row;
    logic signed [VW-1:0] r_vanish;
    logic signed [CW-1:0] r_sway;

    // issue stage
    logic                 r_a_valid;
    p3g_pkg::t_cmd        r_a_cmd;
    logic [KW-1:0]        r_a_k;
    logic signed [PW-1:0] r_a_prod;
    p3g_pkg::t_line_flags r_a_flags;

    // output register
    logic                           r_m_valid;
    logic [p3g_pkg::M_TDATA_W-1:0]  r_m_tdata;
    logic                           r_m_tuser;
    logic                           r_m_tlast;

    logic                 out_free;
    logic                 a_done;
    logic                 s_accept;
    p3g_pkg::t_cmd        s_cmd;
    logic [HW-1:0]        eff_height;
    logic [LW-1:0]        s_line;
    logic signed [DW-1:0] s_diff;
    p3g_pkg::t_line_flags s_flags;

    logic signed [CW-1:0] n_vscroll;
    logic signed [CW-1:0] n_horizon;
    logic [HW-1:0]        n_start_row;
    logic signed [VW-1:0] n_vanish;
    logic [CW-1:0]        n_fwd;

    logic [p3g_pkg::COLOR_W-1:0]  pal_color;
    logic signed [p3g_pkg::SCROLL_W-1:0] ramp_scroll;

    assign o_cfg_ready = 1'b1;

    assign eff_height = ({1'b0, r_screen_height} > (HW+1)'(LINE_LIMIT)) ?
                        HW'(LINE_LIMIT) : r_screen_height;

    assign out_free   = !r_m_valid || i_m_tready;
    assign a_done     = r_a_valid && out_free &&
                        ((r_a_cmd == p3g_pkg::CMD_LINE) || (r_a_k == KW'(7)));
    assign o_s_tready = !r_a_valid || a_done;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_cmd      = p3g_pkg::t_cmd'(i_s_tuser);
    assign s_line     = i_s_tdata[4*CW +: LW];

    always_comb begin
        s_diff         = signed'(DW'(s_line)) - DW'(r_horizon);
        s_flags.beyond = (s_line >= eff_height);
        s_flags.above  = (s_line < r_start_row);
    end

    p3g_frame #(
        .HORIZON_ROW (HORIZON_ROW)
    ) u_frame (
        .i_pitch     (i_s_tdata[CW +: CW]),
        .i_vanish    (i_s_tdata[2*CW +: CW]),
        .i_speed     (i_s_tdata[3*CW +: CW]),
        .i_fwd       (r_fwd),
        .i_height    (eff_height),
        .o_vscroll   (n_vscroll),
        .o_horizon   (n_horizon),
        .o_start_row (n_start_row),
        .o_vanish    (n_vanish),
        .o_fwd       (n_fwd)
    );

    p3g_palette u_palette (
        .i_light (r_light),
        .i_dark  (r_dark),
        .i_band  (r_fwd[10:8]),
        .i_sub   (r_fwd[7:6]),
        .i_index (r_a_k),
        .o_color (pal_color)
    );

    p3g_ramp u_ramp (
        .i_product     (r_a_prod),
        .i_vanish      (r_vanish),
        .i_flags       (r_a_flags),
        .o_line_scroll (ramp_scroll)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_height <= p3g_pkg::SCREEN_HEIGHT_RST;
            r_light         <= p3g_pkg::LIGHT_COLOR_RST;
            r_dark          <= p3g_pkg::DARK_COLOR_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                p3g_pkg::REG_SCREEN_HEIGHT: r_screen_height <= i_cfg_data[HW-1:0];
                p3g_pkg::REG_LIGHT_COLOR:   r_light         <= i_cfg_data;
                p3g_pkg::REG_DARK_COLOR:    r_dark          <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // frame state, updated as a frame update is accepted
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd       <= '0;
            r_horizon   <= CW'(HORIZON_ROW);
            r_vscroll   <= CW'(p3g_pkg::PAD_TOP);
            r_start_row <= HW'(HORIZON_ROW + p3g_pkg::START_PAD);
            r_vanish    <= '0;
            r_sway      <= '0;
        end else if (s_accept && (s_cmd == p3g_pkg::CMD_FRAME)) begin
            r_fwd       <= n_fwd;
            r_horizon   <= n_horizon;
            r_vscroll   <= n_vscroll;
            r_start_row <= n_start_row;
            r_vanish    <= n_vanish;
            r_sway      <= signed'(i_s_tdata[CW-1:0]);
        end
    end

    // issue stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_a_k     <= '0;
        end else if (s_accept) begin
            r_a_valid <= 1'b1;
            r_a_k     <= '0;
        end else if (a_done) begin
            r_a_valid <= 1'b0;
            r_a_k     <= '0;
        end else if (r_a_valid && out_free) begin
            r_a_k     <= r_a_k + KW'(1);
        end
    end

    // issue stage payload; sway product taken against the current frame state
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_a_cmd   <= s_cmd;
            r_a_prod  <= PW'(r_sway) * PW'(s_diff);
            r_a_flags <= s_flags;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (out_free) begin
            r_m_valid <= r_a_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_a_valid && out_free) begin
            if (r_a_cmd == p3g_pkg::CMD_FRAME) begin
                r_m_tdata <= {2'b00, p3g_pkg::SCROLL_W'(0), pal_color, r_a_k,
                              r_horizon, r_vscroll};
                r_m_tuser <= 1'b0;
                r_m_tlast <= (r_a_k == KW'(7));
            end else begin
                r_m_tdata <= {2'b00, ramp_scroll, p3g_pkg::COLOR_W'(0), KW'(0),
                              r_horizon, r_vscroll};
                r_m_tuser <= r_a_flags.beyond;
                r_m_tlast <= 1'b1;
            end
        end
    end

    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;
    assign o_m_tlast  = r_m_tlast;

    // a beyond-screen result is always a single-result query
    a_beyond_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser) |-> o_m_tlast)
        else $error("beyond_screen without tlast");

    // non-final results are palette entries with no scroll
    a_mid_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !o_m_tlast) |-> (o_m_tdata[53:47] == 7'd0 && !o_m_tuser))
        else $error("non-final result carries line data");

    // clamped scroll never positive
    a_scroll_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[53] || (o_m_tdata[53:47] == 7'd0)))
        else $error("line_scroll above zero");

    // entry counter only runs for a frame update held in the issue stage
    a_counter_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_k != '0) |-> (r_a_valid && (r_a_cmd == p3g_pkg::CMD_FRAME)))
        else $error("entry counter running outside a frame update");

    // an accepted frame update starts at entry zero
    a_frame_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_accept && (s_cmd == p3g_pkg::CMD_FRAME)) |=> (r_a_valid && (r_a_k == '0)))
        else $error("frame update not started at entry zero");

endmodule
